// ===== rtl/rsas_pkg.sv =====
// shared types and codes for the rotated sorted array search core
package rsas_pkg;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LAST,
        S_PIV,
        S_PVAL,
        S_SRCH,
        S_OUT
    } t_state;

    localparam logic OP_LOAD   = 1'b0;
    localparam logic OP_SEARCH = 1'b1;

    localparam logic REG_ARRAY_LENGTH = 1'b0;

    localparam logic [6:0] LEN_RESET = 7'd1;

endpackage

// ===== rtl/rsas_ram.sv =====
// generic single write port ram with registered read
module rsas_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/rotated_sorted_array_search_core.sv =====
// rotated sorted array search core: element store, pivot search and key search sequencer
//
// channel   dir  handshake                      payload
// s_axis    in   s_axis_tvalid / s_axis_tready  tuser opcode, tdata index and value
// m_axis    out  m_axis_tvalid / m_axis_tready  tuser found flag, tdata index
// apb       in   psel, penable, pwrite, pready  array_length at byte address 0
//
// a search makes one store read per cycle: read of the last element, pivot halving steps,
// read of the pivot element, key halving steps, then the hand-over to the output register;
// the input side is ready only between searches; the output register takes a new word
// only when it is empty or in the same cycle as the waiting result is taken; synchronous
// active-low reset, no clearing pass on the store
module rotated_sorted_array_search_core #(
    parameter int MAX_ELEMENTS = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // element_index[5:0], data_value[37:6], zero pad
    input  logic        s_axis_tuser,   // opcode[0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // found_index[5:0], zero pad
    output logic        m_axis_tuser,   // key_found[0]
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    import rsas_pkg::*;

    localparam int AW = $clog2(MAX_ELEMENTS);
    localparam int SW = AW + 2;

    t_state                 r_state, n_state;
    logic signed [SW-1:0]   r_lo, n_lo;
    logic signed [SW-1:0]   r_hi, n_hi;
    logic signed [31:0]     r_last, n_last;
    logic signed [31:0]     r_key, n_key;
    logic                   r_rfound, n_rfound;
    logic [5:0]             r_ridx, n_ridx;
    logic                   r_ovalid, n_ovalid;
    logic                   r_ofound, n_ofound;
    logic [5:0]             r_oidx, n_oidx;
    logic [6:0]             r_len;

    logic signed [SW-1:0]   eff_n;
    logic signed [SW-1:0]   cur_mid;
    logic                   ram_we;
    logic [AW-1:0]          ram_raddr;
    logic signed [31:0]     ram_rdata;
    logic [5:0]             in_idx;
    logic signed [31:0]     in_data;
    logic                   idx_ok;
    logic                   cfg_wr;

    function automatic logic signed [SW-1:0] f_mid(input logic signed [SW-1:0] a,
                                                   input logic signed [SW-1:0] b);
        logic signed [SW:0] sum;
        sum = {a[SW-1], a} + {b[SW-1], b};
        return sum[SW:1];
    endfunction

    assign in_idx  = s_axis_tdata[5:0];
    assign in_data = s_axis_tdata[37:6];
    assign idx_ok  = ({26'd0, in_idx} < 32'(MAX_ELEMENTS));
    assign cur_mid = f_mid(r_lo, r_hi);

    rsas_ram #(
        .WIDTH(32),
        .DEPTH(MAX_ELEMENTS)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (AW'(in_idx)),
        .i_wdata (in_data),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // length clamped to 1..MAX_ELEMENTS
    always_comb begin
        if (r_len == 7'd0) begin
            eff_n = SW'(1);
        end else if ({25'd0, r_len} > 32'(MAX_ELEMENTS)) begin
            eff_n = SW'(MAX_ELEMENTS);
        end else begin
            eff_n = SW'(r_len);
        end
    end

    // configuration
    assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_ARRAY_LENGTH);
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_ARRAY_LENGTH) ? {25'd0, r_len} : 32'd0;

    always_comb begin
        n_state   = r_state;
        n_lo      = r_lo;
        n_hi      = r_hi;
        n_last    = r_last;
        n_key     = r_key;
        n_rfound  = r_rfound;
        n_ridx    = r_ridx;
        n_ovalid  = r_ovalid;
        n_ofound  = r_ofound;
        n_oidx    = r_oidx;
        ram_we    = 1'b0;
        ram_raddr = AW'(cur_mid);

        if (r_ovalid && m_axis_tready) begin
            n_ovalid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (s_axis_tvalid) begin
                    if (s_axis_tuser == OP_LOAD) begin
                        ram_we = idx_ok;
                    end else begin
                        n_key     = in_data;
                        n_lo      = '0;
                        n_hi      = SW'(eff_n - 1);
                        ram_raddr = AW'(eff_n - 1);
                        n_state   = S_LAST;
                    end
                end
            end
            S_LAST: begin
                n_last = ram_rdata;
                if (r_lo < r_hi) begin
                    ram_raddr = AW'(cur_mid);
                    n_state   = S_PIV;
                end else begin
                    ram_raddr = AW'(r_lo);
                    n_state   = S_PVAL;
                end
            end
            S_PIV: begin
                if (ram_rdata > r_last) begin
                    n_lo = SW'(cur_mid + 1);
                end else begin
                    n_hi = cur_mid;
                end
                if (n_lo < n_hi) begin
                    ram_raddr = AW'(f_mid(n_lo, n_hi));
                end else begin
                    ram_raddr = AW'(n_lo);
                    n_state   = S_PVAL;
                end
            end
            S_PVAL: begin
                // r_lo holds the pivot here
                if (ram_rdata <= r_key && r_key <= r_last) begin
                    n_lo = r_lo;
                    n_hi = SW'(eff_n - 1);
                end else begin
                    n_lo = '0;
                    n_hi = SW'(r_lo - 1);
                end
                if (n_lo <= n_hi) begin
                    ram_raddr = AW'(f_mid(n_lo, n_hi));
                    n_state   = S_SRCH;
                end else begin
                    n_rfound = 1'b0;
                    n_ridx   = '0;
                    n_state  = S_OUT;
                end
            end
            S_SRCH: begin
                if (ram_rdata == r_key) begin
                    n_rfound = 1'b1;
                    n_ridx   = 6'(cur_mid);
                    n_state  = S_OUT;
                end else begin
                    if (ram_rdata > r_key) begin
                        n_hi = SW'(cur_mid - 1);
                    end else begin
                        n_lo = SW'(cur_mid + 1);
                    end
                    if (n_lo <= n_hi) begin
                        ram_raddr = AW'(f_mid(n_lo, n_hi));
                    end else begin
                        n_rfound = 1'b0;
                        n_ridx   = '0;
                        n_state  = S_OUT;
                    end
                end
            end
            S_OUT: begin
                if (!r_ovalid || m_axis_tready) begin
                    n_ovalid = 1'b1;
                    n_ofound = r_rfound;
                    n_oidx   = r_ridx;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
            r_len    <= LEN_RESET;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
            if (cfg_wr) begin
                r_len <= pwdata[6:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_lo     <= n_lo;
        r_hi     <= n_hi;
        r_last   <= n_last;
        r_key    <= n_key;
        r_rfound <= n_rfound;
        r_ridx   <= n_ridx;
        r_ofound <= n_ofound;
        r_oidx   <= n_oidx;
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tuser  = r_ofound;
    assign m_axis_tdata  = {2'b00, r_oidx};

endmodule

// ===== sim/rsas_answer_checker.sv =====
`timescale 1ns / 1ps
// answer checker for the rotated sorted array search core: mirrors the store, predicts and compares
module rsas_answer_checker #(
    parameter int DEPTH = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [39:0] i_s_tdata,   // element_index[5:0], data_value[37:6], zero pad
    input  logic        i_s_tuser,   // opcode[0]
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [7:0]  i_m_tdata,   // found_index[5:0], zero pad
    input  logic        i_m_tuser,   // key_found[0]
    input  logic        i_psel,
    input  logic        i_penable,
    input  logic        i_pwrite,
    input  logic        i_pready,
    input  logic [2:0]  i_paddr,
    input  logic [31:0] i_pwdata,
    output int          o_fail_count,
    output int          o_pending
);

    import rsas_pkg::*;

    typedef struct {
        logic               hit;
        logic [5:0]         pos;
        logic signed [31:0] key;
        int                 seq;
    } t_answer;

    logic signed [31:0] store_mirror [DEPTH];
    logic [6:0]         len_mirror = LEN_RESET;
    t_answer            answer_q [$];
    int                 fails = 0;
    int                 searches = 0;

    function automatic int search_run(int lo, int hi, logic signed [31:0] key);
        int mid;
        while (lo <= hi) begin
            mid = lo + (hi - lo) / 2;
            if (store_mirror[mid] == key) return mid;
            if (store_mirror[mid] > key) hi = mid - 1;
            else lo = mid + 1;
        end
        return -1;
    endfunction

    function automatic t_answer predict_answer(logic signed [31:0] key);
        t_answer ans;
        int      n;
        int      lo;
        int      hi;
        int      mid;
        int      pos;
        if (len_mirror == 7'd0) n = 1;
        else if (len_mirror > DEPTH) n = DEPTH;
        else n = int'(len_mirror);
        // pivot: index of the smallest element, probes compared with the last one
        lo = 0;
        hi = n - 1;
        while (lo < hi) begin
            mid = lo + (hi - lo) / 2;
            if (store_mirror[mid] > store_mirror[n - 1]) lo = mid + 1;
            else hi = mid;
        end
        if (store_mirror[lo] <= key && key <= store_mirror[n - 1]) pos = search_run(lo, n - 1, key);
        else pos = search_run(0, lo - 1, key);
        ans.key = key;
        ans.hit = (pos >= 0);
        ans.pos = (pos >= 0) ? pos[5:0] : 6'd0;
        ans.seq = 0;
        return ans;
    endfunction

    task automatic report_mismatch(input string what);
        $display("mismatch at %0t: %s", $realtime, what);
        fails++;
    endtask

    always @(posedge i_clk) begin : watch
        t_answer ans;
        if (!i_rst_n) begin
            len_mirror = LEN_RESET;
            answer_q.delete();
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                if (answer_q.size() == 0) begin
                    report_mismatch($sformatf("word with no search waiting, flag %0b index %0d",
                                              i_m_tuser, i_m_tdata[5:0]));
                end else begin
                    ans = answer_q.pop_front();
                    if (i_m_tuser !== ans.hit)
                        report_mismatch($sformatf("search %0d key %0d: found flag %0b, wanted %0b",
                                                  ans.seq, ans.key, i_m_tuser, ans.hit));
                    if (i_m_tdata[5:0] !== ans.pos)
                        report_mismatch($sformatf("search %0d key %0d: index %0d, wanted %0d",
                                                  ans.seq, ans.key, i_m_tdata[5:0], ans.pos));
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                if (i_s_tuser == OP_LOAD) begin
                    store_mirror[i_s_tdata[5:0]] = i_s_tdata[37:6];
                end else begin
                    ans = predict_answer(i_s_tdata[37:6]);
                    ans.seq = searches;
                    searches++;
                    answer_q.push_back(ans);
                end
            end
            if (i_psel && i_penable && i_pwrite && i_pready && i_paddr == {REG_ARRAY_LENGTH, 2'b00})
                len_mirror = i_pwdata[6:0];
        end
        o_pending    <= answer_q.size();
        o_fail_count <= fails;
    end

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 1ps
// testbench top for the rotated sorted array search core: stimulus, stalls and verdict
module tb;
    import rsas_pkg::*;

    localparam int           SETTLE_CYCLES = 40;
    localparam int           IDLE_PCT      = 38;
    localparam int           TARGET_ITEMS  = 950;
    localparam logic [2:0]   ADDR_LENGTH   = {REG_ARRAY_LENGTH, 2'b00};
    localparam logic [2:0]   ADDR_UNUSED   = 3'd4;
    localparam longint       VAL_MIN       = -64'sd2147483648;
    localparam longint       VAL_MAX       = 64'sd2147483647;
    localparam longint       VAL_SPAN      = 64'd4294967295;

    logic        i_clk;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata = '0;   // element_index[5:0], data_value[37:6], zero pad
    logic        s_axis_tuser = OP_LOAD;   // opcode[0]
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;   // found_index[5:0], zero pad
    logic        m_axis_tuser;   // key_found[0]
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    logic        stall_en = 1'b1;
    int          fail_count;
    int          pending;
    int          items_sent = 0;
    int          loads_sent = 0;
    int          searches_sent = 0;
    int          len_settings = 0;
    int          len_lo = 127;
    int          len_hi = 0;

    rotated_sorted_array_search_core u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    rsas_answer_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (s_axis_tvalid),
        .i_s_tready   (s_axis_tready),
        .i_s_tdata    (s_axis_tdata),
        .i_s_tuser    (s_axis_tuser),
        .i_m_tvalid   (m_axis_tvalid),
        .i_m_tready   (m_axis_tready),
        .i_m_tdata    (m_axis_tdata),
        .i_m_tuser    (m_axis_tuser),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_pready     (pready),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #20ms;
        $display("status: fail");
        $finish;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) m_axis_tready <= 1'b0;
        else if (stall_en) m_axis_tready <= ($urandom_range(0, 99) >= IDLE_PCT);
        else m_axis_tready <= 1'b1;
    end

    task automatic push_word(input logic op, input logic [5:0] idx, input logic [31:0] val);
        while (stall_en && $urandom_range(0, 99) < IDLE_PCT) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {2'b00, val, idx};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        items_sent++;
        if (op == OP_LOAD) loads_sent++;
        else searches_sent++;
    endtask

    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic apb_write(input logic [2:0] addr, input logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        if (addr == ADDR_LENGTH) begin
            len_settings++;
            if (int'(val[6:0]) < len_lo) len_lo = int'(val[6:0]);
            if (int'(val[6:0]) > len_hi) len_hi = int'(val[6:0]);
        end
    endtask

    task automatic run_phase(input int phase);
        logic signed [31:0] vals [64];
        longint             sorted_v [64];
        longint             span;
        longint             base;
        int                 n;
        int                 cfg;
        int                 kind;
        int                 rot;
        int                 smax;
        int                 n_search;
        int                 j;
        int                 pick;
        logic [31:0]        key;
        pick = $urandom_range(0, 99);
        if (phase == 0) begin
            n = 64; cfg = 127;
        end else if (phase == 1) begin
            n = 64; cfg = 64;
        end else if (pick < 6) begin
            n = 64; cfg = $urandom_range(64, 127);
        end else if (pick < 12) begin
            n = 1; cfg = $urandom_range(0, 1);
        end else if (pick < 22) begin
            n = $urandom_range(13, 63); cfg = n;
        end else begin
            n = $urandom_range(2, 12); cfg = n;
        end
        stall_en <= !(items_sent >= 350 && items_sent < 600);
        wait_idle();
        apb_write(ADDR_LENGTH, 32'(cfg));

        // kinds: repeats, unordered, else distinct rotated sorted
        kind = $urandom_range(0, 99);
        smax = ($urandom_range(0, 1) == 1) ? 3 : 67108863;
        sorted_v[0] = 0;
        for (int i = 1; i < n; i++) begin
            if (kind < 15) sorted_v[i] = sorted_v[i - 1] + longint'($urandom_range(0, 2));
            else sorted_v[i] = sorted_v[i - 1] + longint'($urandom_range(1, smax));
        end
        span = sorted_v[n - 1];
        pick = $urandom_range(0, 9);
        if (pick == 0) base = VAL_MIN;
        else if (pick == 1) base = VAL_MAX - span;
        else base = VAL_MIN + longint'($urandom_range(0, 32'(VAL_SPAN - span)));
        rot = $urandom_range(0, n - 1);
        for (int i = 0; i < n; i++) begin
            if (kind >= 88) vals[i] = $urandom();
            else vals[i] = 32'(base + sorted_v[(i + rot) % n]);
        end
        for (int i = 0; i < n; i++) push_word(OP_LOAD, 6'(i), vals[i]);

        n_search = $urandom_range(3, (n > 16) ? 16 : 10);
        for (int s = 0; s < n_search; s++) begin
            if ($urandom_range(0, 99) < 6)
                push_word(OP_LOAD, 6'($urandom_range(0, 63)), $urandom());
            j = $urandom_range(0, n - 1);
            pick = $urandom_range(0, 99);
            if (pick < 55) key = vals[j];
            else if (pick < 70) key = vals[j] + 32'd1;
            else if (pick < 80) key = vals[j] - 32'd1;
            else if (pick < 88) key = $urandom();
            else if (pick < 94) key = 32'h8000_0000;
            else key = 32'h7fff_ffff;
            push_word(OP_SEARCH, 6'($urandom()), key);
        end
    endtask

    initial begin : stimulus
        int phase;
        int random_start;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // single element at reset length
        push_word(OP_LOAD, 6'd0, 32'd5);
        push_word(OP_SEARCH, 6'h3f, 32'd5);
        push_word(OP_SEARCH, 6'h00, 32'd6);
        push_word(OP_SEARCH, 6'h2a, 32'h8000_0000);
        // zero length behaves as one
        wait_idle();
        apb_write(ADDR_LENGTH, 32'd0);
        push_word(OP_SEARCH, 6'h15, 32'd5);
        push_word(OP_SEARCH, 6'h3f, 32'd4);
        // write to an unmapped register leaves the length alone
        wait_idle();
        apb_write(ADDR_UNUSED, 32'd3);
        push_word(OP_SEARCH, 6'h00, 32'd5);
        // rotated array holding both extremes
        push_word(OP_LOAD, 6'd0, 32'd10);
        push_word(OP_LOAD, 6'd1, 32'h7fff_ffff);
        push_word(OP_LOAD, 6'd2, 32'h8000_0000);
        push_word(OP_LOAD, 6'd3, 32'd0);
        wait_idle();
        apb_write(ADDR_LENGTH, 32'd4);
        push_word(OP_SEARCH, 6'h3f, 32'd10);
        push_word(OP_SEARCH, 6'h00, 32'h7fff_ffff);
        push_word(OP_SEARCH, 6'h2a, 32'h8000_0000);
        push_word(OP_SEARCH, 6'h15, 32'd0);
        push_word(OP_SEARCH, 6'h3f, 32'd7);
        push_word(OP_SEARCH, 6'h00, 32'hffff_ffff);
        push_word(OP_SEARCH, 6'h3f, 32'd11);

        random_start = items_sent;
        phase = 0;
        while (items_sent - random_start < TARGET_ITEMS) begin
            run_phase(phase);
            phase++;
        end

        wait_idle();
        $display("covered %0d loads and %0d searches over %0d length settings from %0d to %0d",
                 loads_sent, searches_sent, len_settings, len_lo, len_hi);
        $display("arrays rotated sorted, with repeats or unordered; keys stored, adjacent, extreme");
        if (fail_count == 0 && pending == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
